// ===== hdl/bmpr_pkg.sv =====
package bmpr_pkg;

    // front parser phase
    typedef enum logic [2:0] {
        PH_COUNT,
        PH_VALUE,
        PH_DX,
        PH_DY,
        PH_ABS,
        PH_PAD
    } t_phase;

    // commands passed from front to back
    typedef enum logic [2:0] {
        OP_NOP,
        OP_RUN,
        OP_LINE,
        OP_END,
        OP_DX,
        OP_DY
    } t_op;

    typedef enum logic [1:0] {
        KIND_RUN  = 2'd0,
        KIND_LINE = 2'd1,
        KIND_END  = 2'd2,
        KIND_ERR  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        RS_RUN,
        RS_DONE,
        RS_FAULT
    } t_run;

    localparam int unsigned CFG_AW = 2;
    localparam int unsigned CFG_DW = 13;

    localparam logic [CFG_AW-1:0] REG_NIBBLE = 2'd0;
    localparam logic [CFG_AW-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_AW-1:0] REG_HEIGHT = 2'd2;

    localparam logic [12:0] WIDTH_RST  = 13'd4096;
    localparam logic [12:0] HEIGHT_RST = 13'd4096;
    localparam logic [12:0] COL_MAX    = 13'd8191;
    localparam logic [7:0]  NIB_MASK   = 8'h0F;

    localparam logic [7:0] ESC_LINE  = 8'd0;
    localparam logic [7:0] ESC_END   = 8'd1;
    localparam logic [7:0] ESC_DELTA = 8'd2;

    typedef struct packed {
        t_op        op;
        logic       restart;
        logic [7:0] len;     // run length, or dx for OP_DX
        logic [7:0] pe;
        logic [7:0] po;
    } t_cmd;

    typedef struct packed {
        t_kind       kind;
        logic [11:0] row;
        logic [11:0] column;
        logic [7:0]  run_length;
        logic [7:0]  pixel_even;
        logic [7:0]  pixel_odd;
    } t_result;

endpackage

// ===== hdl/bmpr_fifo.sv =====
module bmpr_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_empty,
    output logic [W-1:0] o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd, n_wr, n_rd;
    logic [CW-1:0] r_cnt;
    logic          push_ok, pop_ok;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    assign n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= n_wr;
            end
            if (pop_ok) begin
                r_rd <= n_rd;
            end
            if (push_ok && !pop_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/bmpr_front.sv =====
module bmpr_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_restart,
    input  logic            i_nibble_mode,
    input  logic            i_take,
    input  logic [7:0]      i_byte,
    input  logic            i_restart,
    output bmpr_pkg::t_cmd  o_cmd
);

    bmpr_pkg::t_phase r_phase, n_phase, s_phase;
    logic [7:0]       r_held, n_held, s_held;
    logic [7:0]       r_abs, n_abs, s_abs;
    logic             r_pad, n_pad, s_pad;
    logic [8:0]       b_inc;
    logic [7:0]       abs_step;
    logic [7:0]       abs_rem;
    logic [7:0]       hi_nib, lo_nib;

    // a restart flag clears the parser before this byte
    assign s_phase = i_restart ? bmpr_pkg::PH_COUNT : r_phase;
    assign s_held  = i_restart ? 8'd0 : r_held;
    assign s_abs   = i_restart ? 8'd0 : r_abs;
    assign s_pad   = i_restart ? 1'b0 : r_pad;

    assign b_inc    = {1'b0, i_byte} + 9'd1;
    assign hi_nib   = {4'd0, i_byte[7:4]};
    assign lo_nib   = i_byte & bmpr_pkg::NIB_MASK;
    assign abs_step = (i_nibble_mode && (s_abs >= 8'd2)) ? 8'd2 : 8'd1;
    assign abs_rem  = (s_abs >= abs_step) ? s_abs - abs_step : 8'd0;

    // next parser state
    always_comb begin
        n_phase = s_phase;
        n_held  = s_held;
        n_abs   = s_abs;
        n_pad   = s_pad;
        unique case (s_phase)
            bmpr_pkg::PH_COUNT: begin
                n_held  = i_byte;
                n_phase = bmpr_pkg::PH_VALUE;
            end
            bmpr_pkg::PH_VALUE: begin
                n_phase = bmpr_pkg::PH_COUNT;
                if (s_held == 8'd0) begin
                    if (i_byte == bmpr_pkg::ESC_DELTA) begin
                        n_phase = bmpr_pkg::PH_DX;
                    end else if (i_byte != bmpr_pkg::ESC_LINE &&
                                 i_byte != bmpr_pkg::ESC_END) begin
                        n_abs   = i_byte;
                        n_pad   = i_nibble_mode ? b_inc[1] : i_byte[0];
                        n_phase = bmpr_pkg::PH_ABS;
                    end
                end
            end
            bmpr_pkg::PH_DX: begin
                n_phase = bmpr_pkg::PH_DY;
            end
            bmpr_pkg::PH_DY: begin
                n_phase = bmpr_pkg::PH_COUNT;
            end
            bmpr_pkg::PH_ABS: begin
                n_abs = abs_rem;
                if (abs_rem == 8'd0) begin
                    n_phase = s_pad ? bmpr_pkg::PH_PAD : bmpr_pkg::PH_COUNT;
                end
            end
            bmpr_pkg::PH_PAD: begin
                n_pad   = 1'b0;
                n_phase = bmpr_pkg::PH_COUNT;
            end
            default: begin
                n_phase = bmpr_pkg::PH_COUNT;
            end
        endcase
    end

    // command for the back end
    always_comb begin
        o_cmd         = '0;
        o_cmd.op      = bmpr_pkg::OP_NOP;
        o_cmd.restart = i_restart;
        unique case (s_phase)
            bmpr_pkg::PH_VALUE: begin
                if (s_held != 8'd0) begin
                    o_cmd.op  = bmpr_pkg::OP_RUN;
                    o_cmd.len = s_held;
                    o_cmd.pe  = i_nibble_mode ? hi_nib : i_byte;
                    o_cmd.po  = (!i_nibble_mode || s_held == 8'd1) ? o_cmd.pe : lo_nib;
                end else if (i_byte == bmpr_pkg::ESC_LINE) begin
                    o_cmd.op = bmpr_pkg::OP_LINE;
                end else if (i_byte == bmpr_pkg::ESC_END) begin
                    o_cmd.op = bmpr_pkg::OP_END;
                end
            end
            bmpr_pkg::PH_DX: begin
                o_cmd.op  = bmpr_pkg::OP_DX;
                o_cmd.len = i_byte;
            end
            bmpr_pkg::PH_DY: begin
                o_cmd.op = bmpr_pkg::OP_DY;
            end
            bmpr_pkg::PH_ABS: begin
                o_cmd.op  = bmpr_pkg::OP_RUN;
                o_cmd.len = abs_step;
                o_cmd.pe  = i_nibble_mode ? hi_nib : i_byte;
                o_cmd.po  = (!i_nibble_mode || abs_step == 8'd1) ? o_cmd.pe : lo_nib;
            end
            default: begin
                o_cmd.op = bmpr_pkg::OP_NOP;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_restart) begin
            r_phase <= bmpr_pkg::PH_COUNT;
            r_held  <= 8'd0;
            r_abs   <= 8'd0;
            r_pad   <= 1'b0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_held  <= n_held;
            r_abs   <= n_abs;
            r_pad   <= n_pad;
        end
    end

endmodule

// ===== hdl/bmpr_back.sv =====
module bmpr_back #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_restart,
    input  logic [12:0]       i_line_width,
    input  logic [12:0]       i_image_height,
    input  logic              i_cmd_valid,
    input  bmpr_pkg::t_cmd    i_cmd,
    output logic              o_cmd_pop,
    input  logic              i_out_full,
    output logic              o_res_push,
    output bmpr_pkg::t_result o_res
);

    localparam int RW = $clog2(MAX_HEIGHT);

    logic [12:0]     r_col, n_col, s_col;
    logic [RW-1:0]   r_row, n_row, s_row, start_row;
    bmpr_pkg::t_run  r_state, n_state, s_state;
    logic            r_fresh;   // a start is due after reset or a register write
    logic            fire, start;
    logic [12:0]     w_eff;
    logic [17:0]     w18, h18, h_eff;
    logic [13:0]     sum;
    logic [31:0]     row32;
    logic            run_bad, dy_bad;

    // line width clamped to MAX_WIDTH; height clamped to 1..MAX_HEIGHT
    assign w18   = {5'd0, i_line_width};
    assign w_eff = (w18 > 18'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : i_line_width;
    assign h18   = {5'd0, i_image_height};

    always_comb begin
        h_eff = h18;
        if (h18 == 18'd0) begin
            h_eff = 18'd1;
        end else if (h18 > 18'(MAX_HEIGHT)) begin
            h_eff = 18'(MAX_HEIGHT);
        end
    end

    assign start_row = RW'(h_eff - 18'd1);

    assign fire      = i_cmd_valid && !i_out_full;
    assign o_cmd_pop = fire;
    assign start     = r_fresh || i_cmd.restart;

    assign s_col   = start ? 13'd0 : r_col;
    assign s_row   = start ? start_row : r_row;
    assign s_state = start ? bmpr_pkg::RS_RUN : r_state;

    assign sum     = {1'b0, s_col} + {6'd0, i_cmd.len};
    assign run_bad = (sum > {1'b0, w_eff});
    assign dy_bad  = (s_col > w_eff);
    assign row32   = 32'(s_row);

    // next position and run state
    always_comb begin
        n_col   = s_col;
        n_row   = s_row;
        n_state = s_state;
        if (s_state == bmpr_pkg::RS_RUN) begin
            unique case (i_cmd.op)
                bmpr_pkg::OP_RUN: begin
                    if (run_bad) begin
                        n_state = bmpr_pkg::RS_FAULT;
                    end else begin
                        n_col = sum[12:0];
                    end
                end
                bmpr_pkg::OP_LINE: begin
                    n_col = 13'd0;
                    if (s_row == '0) begin
                        n_state = bmpr_pkg::RS_DONE;
                    end else begin
                        n_row = s_row - 1'b1;
                    end
                end
                bmpr_pkg::OP_END: begin
                    n_state = bmpr_pkg::RS_DONE;
                end
                bmpr_pkg::OP_DX: begin
                    n_col = (sum > {1'b0, bmpr_pkg::COL_MAX}) ? bmpr_pkg::COL_MAX : sum[12:0];
                end
                bmpr_pkg::OP_DY: begin
                    if (dy_bad) begin
                        n_state = bmpr_pkg::RS_FAULT;
                    end
                end
                default: begin
                    n_state = s_state;
                end
            endcase
        end
    end

    // result for the output queue
    always_comb begin
        o_res      = '0;
        o_res.kind = bmpr_pkg::KIND_ERR;
        o_res.row  = row32[11:0];
        o_res_push = 1'b0;
        if (fire && s_state == bmpr_pkg::RS_RUN) begin
            unique case (i_cmd.op)
                bmpr_pkg::OP_RUN: begin
                    o_res_push = 1'b1;
                    if (!run_bad) begin
                        o_res.kind       = bmpr_pkg::KIND_RUN;
                        o_res.column     = s_col[11:0];
                        o_res.run_length = i_cmd.len;
                        o_res.pixel_even = i_cmd.pe;
                        o_res.pixel_odd  = i_cmd.po;
                    end
                end
                bmpr_pkg::OP_LINE: begin
                    o_res_push = 1'b1;
                    o_res.kind = bmpr_pkg::KIND_LINE;
                end
                bmpr_pkg::OP_END: begin
                    o_res_push = 1'b1;
                    o_res.kind = bmpr_pkg::KIND_END;
                end
                bmpr_pkg::OP_DY: begin
                    o_res_push = dy_bad;
                end
                default: begin
                    o_res_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_restart) begin
            r_fresh <= 1'b1;
            r_col   <= 13'd0;
            r_row   <= '0;
            r_state <= bmpr_pkg::RS_RUN;
        end else if (fire) begin
            r_fresh <= 1'b0;
            r_col   <= n_col;
            r_row   <= n_row;
            r_state <= n_state;
        end
    end

endmodule

// ===== hdl/bmp_rle_decoder.sv =====
// Path: the front parser turns an accepted byte into a command for the command queue;
// the back end pops it, updates the position and pushes a result into the result queue.
// Throughput: one byte per cycle while full is low; the back end stalls when results back up.
// Command and result queues are two items deep, so either side may stall alone.
// Reset (i_rst_n low, synchronous): queues empty, RLE8 mode, width and height 4096,
// decoding starts at column 0 of the top stored row. A register write also restarts.
module bmp_rle_decoder #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bmpr_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  logic [bmpr_pkg::CFG_DW-1:0]   i_cfg_wdata,
    input  logic                          push,
    output logic                          full,
    input  logic [7:0]                    i_byte_in,
    input  logic                          i_restart,
    output logic                          empty,
    input  logic                          pop,
    output logic [1:0]                    o_kind,
    output logic [11:0]                   o_row,
    output logic [11:0]                   o_column,
    output logic [7:0]                    o_run_length,
    output logic [7:0]                    o_pixel_even,
    output logic [7:0]                    o_pixel_odd
);

    logic              r_nibble_mode;
    logic [12:0]       r_line_width;
    logic [12:0]       r_image_height;
    logic              cfg_restart;
    logic              take;
    bmpr_pkg::t_cmd    front_cmd, back_cmd;
    logic              cmd_empty, cmd_pop;
    logic              out_full, res_push;
    bmpr_pkg::t_result back_res, out_res;

    assign cfg_restart = i_cfg_we && (i_cfg_addr == bmpr_pkg::REG_NIBBLE ||
                                      i_cfg_addr == bmpr_pkg::REG_WIDTH ||
                                      i_cfg_addr == bmpr_pkg::REG_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nibble_mode  <= 1'b0;
            r_line_width   <= bmpr_pkg::WIDTH_RST;
            r_image_height <= bmpr_pkg::HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                bmpr_pkg::REG_NIBBLE: r_nibble_mode  <= i_cfg_wdata[0];
                bmpr_pkg::REG_WIDTH:  r_line_width   <= i_cfg_wdata;
                bmpr_pkg::REG_HEIGHT: r_image_height <= i_cfg_wdata;
                default: begin
                    r_nibble_mode <= r_nibble_mode;
                end
            endcase
        end
    end

    assign take = push && !full;

    bmpr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_restart (cfg_restart),
        .i_nibble_mode (r_nibble_mode),
        .i_take        (take),
        .i_byte        (i_byte_in),
        .i_restart     (i_restart),
        .o_cmd         (front_cmd)
    );

    bmpr_fifo #(
        .W     ($bits(bmpr_pkg::t_cmd)),
        .DEPTH (2)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .o_full  (full),
        .i_pop   (cmd_pop),
        .o_empty (cmd_empty),
        .o_data  (back_cmd)
    );

    bmpr_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_restart  (cfg_restart),
        .i_line_width   (r_line_width),
        .i_image_height (r_image_height),
        .i_cmd_valid    (!cmd_empty),
        .i_cmd          (back_cmd),
        .o_cmd_pop      (cmd_pop),
        .i_out_full     (out_full),
        .o_res_push     (res_push),
        .o_res          (back_res)
    );

    bmpr_fifo #(
        .W     ($bits(bmpr_pkg::t_result)),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_res),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (out_res)
    );

    assign o_kind       = out_res.kind;
    assign o_row        = out_res.row;
    assign o_column     = out_res.column;
    assign o_run_length = out_res.run_length;
    assign o_pixel_even = out_res.pixel_even;
    assign o_pixel_odd  = out_res.pixel_odd;

endmodule

// ===== hdl/bmpr_checker.sv =====
module bmpr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  o_kind,
    input logic [11:0] o_row,
    input logic [11:0] o_column,
    input logic [7:0]  o_run_length,
    input logic [7:0]  o_pixel_even,
    input logic [7:0]  o_pixel_odd
);

    // queues come out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> empty && !full)
        else $error("queues not empty after reset");

    // only run items carry column, run length and pixel data
    a_nonrun_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind != bmpr_pkg::KIND_RUN) |->
            (o_column == 12'd0 && o_run_length == 8'd0 &&
             o_pixel_even == 8'd0 && o_pixel_odd == 8'd0))
        else $error("non-run item carries run data");

    // a run writes at least one pixel, and a single pixel has one value
    a_run_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == bmpr_pkg::KIND_RUN) |->
            (o_run_length != 8'd0 &&
             (o_run_length != 8'd1 || o_pixel_odd == o_pixel_even)))
        else $error("malformed run item");

    // a waiting item holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=>
            (!empty && $stable(o_kind) && $stable(o_row) && $stable(o_column) &&
             $stable(o_run_length) && $stable(o_pixel_even) && $stable(o_pixel_odd)))
        else $error("waiting item changed");

endmodule

bind bmp_rle_decoder bmpr_checker u_bmpr_checker (.*);

// ===== tb/bmp_rle_decoder_tb.sv =====
module bmp_rle_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_W = 4096;
    localparam int MAX_H = 4096;

    typedef struct packed {
        logic [7:0] data;
        logic       restart;
    } t_byte_item;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_we = 1'b0;
    logic [bmpr_pkg::CFG_AW-1:0]   i_cfg_addr = '0;
    logic [bmpr_pkg::CFG_DW-1:0]   i_cfg_wdata = '0;
    logic                          push = 1'b0;
    logic                          full;
    logic [7:0]                    i_byte_in = '0;
    logic                          i_restart = 1'b0;
    logic                          empty;
    logic                          pop = 1'b0;
    logic [1:0]                    o_kind;
    logic [11:0]                   o_row;
    logic [11:0]                   o_column;
    logic [7:0]                    o_run_length;
    logic [7:0]                    o_pixel_even;
    logic [7:0]                    o_pixel_odd;

    bmp_rle_decoder #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .push         (push),
        .full         (full),
        .i_byte_in    (i_byte_in),
        .i_restart    (i_restart),
        .empty        (empty),
        .pop          (pop),
        .o_kind       (o_kind),
        .o_row        (o_row),
        .o_column     (o_column),
        .o_run_length (o_run_length),
        .o_pixel_even (o_pixel_even),
        .o_pixel_odd  (o_pixel_odd)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Decoder predictor
    // ------------------------------------------------------------------
    logic        cfg_nibble = 1'b0;
    logic [12:0] cfg_width  = bmpr_pkg::WIDTH_RST;
    logic [12:0] cfg_height = bmpr_pkg::HEIGHT_RST;

    bmpr_pkg::t_phase  dec_phase;
    logic [7:0]        dec_count;
    logic [7:0]        dec_abs_left;
    logic              dec_pad;
    int                dec_col;
    logic [11:0]       dec_row;
    bmpr_pkg::t_run    dec_state;

    bmpr_pkg::t_result predicted_results[$];
    t_byte_item        stream_bytes[$];
    int                fail_count = 0;

    function automatic int width_limit();
        int w;
        w = int'(cfg_width);
        if (w > MAX_W) w = MAX_W;
        return w;
    endfunction

    function automatic void restart_image();
        int h;
        h = int'(cfg_height);
        if (h == 0) h = 1;
        if (h > MAX_H) h = MAX_H;
        dec_phase    = bmpr_pkg::PH_COUNT;
        dec_count    = '0;
        dec_abs_left = '0;
        dec_pad      = 1'b0;
        dec_col      = 0;
        dec_row      = 12'(h - 1);
        dec_state    = bmpr_pkg::RS_RUN;
    endfunction

    function automatic bmpr_pkg::t_result make_result(bmpr_pkg::t_kind k, int col, int len,
                                                      logic [7:0] pe, logic [7:0] po);
        bmpr_pkg::t_result r;
        r.kind       = k;
        r.row        = dec_row;
        r.column     = 12'(col);
        r.run_length = 8'(len);
        r.pixel_even = pe;
        r.pixel_odd  = po;
        return r;
    endfunction

    // a run that would reach past the line is an error and writes nothing
    function automatic bmpr_pkg::t_result place_run(int len, logic [7:0] pe,
                                                    logic [7:0] po);
        bmpr_pkg::t_result r;
        if (len == 1) po = pe;
        if (dec_col + len > width_limit()) begin
            dec_state = bmpr_pkg::RS_FAULT;
            r = make_result(bmpr_pkg::KIND_ERR, 0, 0, 8'd0, 8'd0);
        end else begin
            r = make_result(bmpr_pkg::KIND_RUN, dec_col, len, pe, po);
            dec_col += len;
        end
        return r;
    endfunction

    function automatic bit decode_byte(input logic [7:0] b, input logic rs,
                                       output bmpr_pkg::t_result r);
        logic [7:0] pe;
        logic [7:0] po;
        logic [8:0] b_inc;
        int         n;
        r = '0;
        if (rs) restart_image();
        if (dec_state != bmpr_pkg::RS_RUN) return 1'b0;
        if (cfg_nibble) begin
            pe = {4'h0, b[7:4]};
            po = b & bmpr_pkg::NIB_MASK;
        end else begin
            pe = b;
            po = b;
        end
        case (dec_phase)
            bmpr_pkg::PH_COUNT: begin
                dec_count = b;
                dec_phase = bmpr_pkg::PH_VALUE;
                return 1'b0;
            end
            bmpr_pkg::PH_VALUE: begin
                dec_phase = bmpr_pkg::PH_COUNT;
                if (dec_count != 8'd0) begin
                    r = place_run(int'(dec_count), pe, po);
                    return 1'b1;
                end
                if (b == bmpr_pkg::ESC_LINE) begin
                    r = make_result(bmpr_pkg::KIND_LINE, 0, 0, 8'd0, 8'd0);
                    dec_col = 0;
                    if (dec_row == 12'd0) dec_state = bmpr_pkg::RS_DONE;
                    else dec_row = dec_row - 12'd1;
                    return 1'b1;
                end
                if (b == bmpr_pkg::ESC_END) begin
                    dec_state = bmpr_pkg::RS_DONE;
                    r = make_result(bmpr_pkg::KIND_END, 0, 0, 8'd0, 8'd0);
                    return 1'b1;
                end
                if (b == bmpr_pkg::ESC_DELTA) begin
                    dec_phase = bmpr_pkg::PH_DX;
                    return 1'b0;
                end
                // absolute run; data is padded to an even byte count
                dec_abs_left = b;
                b_inc = {1'b0, b} + 9'd1;
                dec_pad = cfg_nibble ? b_inc[1] : b[0];
                dec_phase = bmpr_pkg::PH_ABS;
                return 1'b0;
            end
            bmpr_pkg::PH_DX: begin
                dec_col += int'(b);
                if (dec_col > int'(bmpr_pkg::COL_MAX)) dec_col = int'(bmpr_pkg::COL_MAX);
                dec_phase = bmpr_pkg::PH_DY;
                return 1'b0;
            end
            bmpr_pkg::PH_DY: begin
                dec_phase = bmpr_pkg::PH_COUNT;
                if (dec_col > width_limit()) begin
                    dec_state = bmpr_pkg::RS_FAULT;
                    r = make_result(bmpr_pkg::KIND_ERR, 0, 0, 8'd0, 8'd0);
                    return 1'b1;
                end
                return 1'b0;
            end
            bmpr_pkg::PH_ABS: begin
                n = (cfg_nibble && dec_abs_left >= 8'd2) ? 2 : 1;
                dec_abs_left = (int'(dec_abs_left) >= n) ? dec_abs_left - 8'(n) : 8'd0;
                if (dec_abs_left == 8'd0)
                    dec_phase = dec_pad ? bmpr_pkg::PH_PAD : bmpr_pkg::PH_COUNT;
                r = place_run(n, pe, po);
                return 1'b1;
            end
            bmpr_pkg::PH_PAD: begin
                dec_pad = 1'b0;
                dec_phase = bmpr_pkg::PH_COUNT;
                return 1'b0;
            end
            default: begin
                dec_phase = bmpr_pkg::PH_COUNT;
                return 1'b0;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: bursts of items with random gaps
    // ------------------------------------------------------------------
    logic       took_item = 1'b0;
    int         burst_left = 0;
    int         gap_left = 0;
    t_byte_item next_item;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (push && !took_item) begin
            // item still waiting for acceptance
        end else if (gap_left > 0) begin
            gap_left--;
            push <= 1'b0;
            i_byte_in <= 8'($urandom);
        end else if (stream_bytes.size() > 0) begin
            next_item = stream_bytes.pop_front();
            i_byte_in <= next_item.data;
            i_restart <= next_item.restart;
            push <= 1'b1;
            if (burst_left > 1) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(1, 24);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            end
        end else begin
            push <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: pop pattern switches between draining, random and slow
    // ------------------------------------------------------------------
    int drain_mode = 0;
    int drain_left = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (drain_left == 0) begin
                drain_mode = $urandom_range(0, 2);
                drain_left = $urandom_range(16, 160);
            end
            drain_left--;
            case (drain_mode)
                0: pop <= 1'b1;
                1: pop <= 1'($urandom_range(0, 1));
                default: pop <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predicts on accepted items, checks popped results
    // ------------------------------------------------------------------
    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            fail_count++;
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        bmpr_pkg::t_result want;
        bmpr_pkg::t_result fresh;
        if (!i_rst_n) begin
            took_item <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (predicted_results.size() == 0) begin
                    fail_count++;
                    $error("result with none expected: kind %0d row %0d", o_kind, o_row);
                end else begin
                    want = predicted_results.pop_front();
                    check_field("kind", want.kind, o_kind);
                    check_field("row", want.row, o_row);
                    check_field("column", want.column, o_column);
                    check_field("run_length", want.run_length, o_run_length);
                    check_field("pixel_even", want.pixel_even, o_pixel_even);
                    check_field("pixel_odd", want.pixel_odd, o_pixel_odd);
                end
            end
            if (push && !full) begin
                if (decode_byte(i_byte_in, i_restart, fresh))
                    predicted_results.push_back(fresh);
            end
            took_item <= push && !full;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    logic need_restart = 1'b0;
    int   item_total = 0;
    int   gen_w;
    int   gen_h;
    int   gen_col;
    int   gen_rows;

    task automatic add_byte(input logic [7:0] b);
        stream_bytes.push_back('{data: b, restart: need_restart});
        need_restart = 1'b0;
        item_total++;
    endtask

    task automatic wait_idle();
        while (stream_bytes.size() != 0 || push || predicted_results.size() != 0)
            @(posedge i_clk);
        // bytes that give no result may still be in the pipeline
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic nib, input logic [12:0] w, input logic [12:0] h);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= bmpr_pkg::REG_NIBBLE;
        i_cfg_wdata <= {12'd0, nib};
        @(negedge i_clk);
        i_cfg_addr <= bmpr_pkg::REG_WIDTH;
        i_cfg_wdata <= w;
        @(negedge i_clk);
        i_cfg_addr <= bmpr_pkg::REG_HEIGHT;
        i_cfg_wdata <= h;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_nibble = nib;
        cfg_width = w;
        cfg_height = h;
        restart_image();
    endtask

    task automatic new_image();
        need_restart = 1'b1;
        gen_col = 0;
        gen_rows = gen_h;
    endtask

    function automatic bit gen_nibble();
        return cfg_nibble;
    endfunction

    // mostly well-formed images for the current settings, with some
    // overruns, stray restarts and noise bytes mixed in
    task automatic gen_image(input int budget);
        int stop_at;
        int room;
        int pick;
        int n;
        int hi;
        int nbytes;
        logic [8:0] n_inc;
        stop_at = item_total + budget;
        new_image();
        while (item_total < stop_at) begin
            if ($urandom_range(0, 49) == 0) new_image();
            room = gen_w - gen_col;
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                if (room >= 1 && $urandom_range(0, 19) != 0)
                    n = $urandom_range(1, (room > 255) ? 255 : room);
                else
                    n = $urandom_range(1, 255);
                add_byte(8'(n));
                add_byte(8'($urandom));
                gen_col += n;
                if (gen_col > gen_w) new_image();
            end else if (pick < 65) begin
                hi = (room > 40) ? 40 : room;
                if (hi >= 3 && $urandom_range(0, 9) != 0)
                    n = $urandom_range(3, hi);
                else
                    n = $urandom_range(3, 40);
                add_byte(bmpr_pkg::ESC_LINE);
                add_byte(8'(n));
                nbytes = gen_nibble() ? (n + 1) / 2 : n;
                for (int i = 0; i < nbytes; i++) add_byte(8'($urandom));
                n_inc = 9'(n + 1);
                if (gen_nibble() ? n_inc[1] : n_inc[0] == 1'b0 && n[0]) add_byte(8'($urandom));
                gen_col += n;
                if (gen_col > gen_w) new_image();
            end else if (pick < 75) begin
                if (room > 0 && $urandom_range(0, 4) != 0)
                    n = $urandom_range(0, (room > 255) ? 255 : room);
                else
                    n = $urandom_range(0, 255);
                add_byte(bmpr_pkg::ESC_LINE);
                add_byte(bmpr_pkg::ESC_DELTA);
                add_byte(8'(n));
                add_byte(8'($urandom));
                gen_col += n;
                if (gen_col > gen_w) new_image();
            end else if (pick < 90) begin
                add_byte(bmpr_pkg::ESC_LINE);
                add_byte(bmpr_pkg::ESC_LINE);
                gen_col = 0;
                if (gen_rows <= 1) new_image();
                else gen_rows--;
            end else if (pick < 94) begin
                add_byte(bmpr_pkg::ESC_LINE);
                add_byte(bmpr_pkg::ESC_END);
                new_image();
            end else begin
                add_byte(8'($urandom));
            end
        end
    endtask

    task automatic run_phase(input logic nib, input int w, input int h, input int budget);
        wait_idle();
        write_regs(nib, 13'(w), 13'(h));
        gen_w = (w > MAX_W) ? MAX_W : w;
        gen_h = (h == 0) ? 1 : ((h > MAX_H) ? MAX_H : h);
        gen_image(budget);
    endtask

    initial begin
        restart_image();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // 8-bit mode at reset settings: longest run, single pixel, line end,
        // odd absolute run with pad, delta, end of picture, byte while finished
        add_byte(8'd255); add_byte(8'hA5);
        add_byte(8'd1);   add_byte(8'h00);
        add_byte(bmpr_pkg::ESC_LINE); add_byte(bmpr_pkg::ESC_LINE);
        add_byte(bmpr_pkg::ESC_LINE); add_byte(8'd3);
        add_byte(8'h11); add_byte(8'h22); add_byte(8'h33); add_byte(8'hEE);
        add_byte(bmpr_pkg::ESC_LINE); add_byte(bmpr_pkg::ESC_DELTA);
        add_byte(8'hFF); add_byte(8'h07);
        add_byte(bmpr_pkg::ESC_LINE); add_byte(bmpr_pkg::ESC_END);
        add_byte(8'h5A);

        // 4-bit mode, narrow single-row image
        wait_idle();
        write_regs(1'b1, 13'd8, 13'd1);
        add_byte(8'd5); add_byte(8'h3C);
        add_byte(bmpr_pkg::ESC_LINE); add_byte(8'd3); add_byte(8'hAB); add_byte(8'hC0);
        add_byte(8'd1); add_byte(8'hFF);          // past the line end
        need_restart = 1'b1;
        add_byte(bmpr_pkg::ESC_LINE); add_byte(bmpr_pkg::ESC_DELTA);
        add_byte(8'd9); add_byte(8'd0);
        need_restart = 1'b1;
        // line end on the last row
        add_byte(bmpr_pkg::ESC_LINE); add_byte(bmpr_pkg::ESC_LINE);
        add_byte(8'h77);

        run_phase(1'b0, 16, 4, 130);
        run_phase(1'b1, 16, 4, 130);
        run_phase(1'b0, 1, 2, 50);
        run_phase(1'b1, 0, 3, 40);
        run_phase(1'b0, 8191, 0, 90);
        run_phase(1'b1, 4096, 8191, 110);
        run_phase(1'b0, $urandom_range(17, 300), $urandom_range(2, 12), 200);
        run_phase(1'b1, $urandom_range(2, 64), $urandom_range(1, 8), 200);
        run_phase(1'b1, 1, 1, 40);

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== bmp_rle_decoder.f =====
hdl/bmpr_pkg.sv
hdl/bmpr_fifo.sv
hdl/bmpr_front.sv
hdl/bmpr_back.sv
hdl/bmp_rle_decoder.sv
hdl/bmpr_checker.sv
tb/bmp_rle_decoder_tb.sv
